/* design/hbw_pkg.sv */
`default_nettype none
package hbw_pkg;

  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_UNREGISTER = 2'd1;
  localparam logic [1:0] OP_FEED       = 2'd2;
  localparam logic [1:0] OP_TICK       = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] client_key;
    logic [15:0] timeout_sec;
    logic [7:0]  miss_limit;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_index;
    logic [4:0] timeouts_seen;
    logic       stuck;
    logic [3:0] stuck_slot;
    logic       halted;
  } out_t;

  // one slot as stored in the slot memory
  typedef struct packed {
    logic [15:0] key;
    logic [15:0] timeout;
    logic [7:0]  miss_limit;
    logic [7:0]  misses;
    logic [15:0] elapsed;
  } entry_t;

  // tick update of an unfed slot
  typedef struct packed {
    entry_t nxt;
    logic   hit;
    logic   stuck;
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage
`default_nettype wire

/* design/multi_slot_heartbeat_watchdog.sv */
`default_nettype none
// Heartbeat watchdog over SLOTS client slots. Keys, timeouts, limits and counters sit in a
// one-read/one-write slot memory; active and fed flags are flip-flops. Every op walks the
// slot memory one entry per cycle, as the memory has a single read port, except a tick
// once the block has halted, which skips the walk. Register, unregister and feed stop at the
// matching slot or after the last slot; a tick stops at a stuck slot or after the last slot.
// One op is in flight at a time; the next beat is taken as soon as the result is in the
// output register.
module multi_slot_heartbeat_watchdog import hbw_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  state_t            state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [15:0]       key_r, key_nxt;
  logic [15:0]       tmo_r, tmo_nxt;
  logic [7:0]        lim_r, lim_nxt;
  logic [IW-1:0]     iss_r, iss_nxt;
  logic              iss_more_r, iss_more_nxt;
  logic              pv_r, pv_nxt;
  logic [IW-1:0]     p_r, p_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IW-1:0]     free_idx_r, free_idx_nxt;
  logic [4:0]        seen_r, seen_nxt;
  logic              halted_r, halted_nxt;
  logic [SLOTS-1:0]  active_r, active_nxt;
  logic [SLOTS-1:0]  fed_r, fed_nxt;
  out_t              res_r, res_nxt;
  logic              out_valid_r;
  out_t              out_r;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  entry_t            rd_data;
  upd_t              upd;

  logic              key_hit;
  logic              last_p;
  logic              stop;
  logic [IW-1:0]     fidx;

  hbw_mem #(.DEPTH(SLOTS), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (iss_r),
    .rdata (rd_data)
  );

  hbw_slot_upd u_upd (
    .ent (rd_data),
    .upd (upd)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    tmo_nxt        = tmo_r;
    lim_nxt        = lim_r;
    iss_nxt        = iss_r;
    iss_more_nxt   = iss_more_r;
    pv_nxt         = 1'b0;
    p_nxt          = p_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    seen_nxt       = seen_r;
    halted_nxt     = halted_r;
    active_nxt     = active_r;
    fed_nxt        = fed_r;
    res_nxt        = res_r;
    mem_we         = 1'b0;
    mem_waddr      = p_r;
    mem_wdata      = rd_data;
    mem_re         = 1'b0;
    key_hit        = active_r[p_r] && (rd_data.key == key_r);
    last_p         = (p_r == LAST);
    stop           = 1'b0;
    fidx           = free_found_r ? free_idx_r : p_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.op;
          key_nxt        = in_data.client_key;
          tmo_nxt        = (in_data.timeout_sec == 16'd0) ? 16'd1 : in_data.timeout_sec;
          lim_nxt        = (in_data.miss_limit == 8'd0) ? 8'd1 : in_data.miss_limit;
          iss_nxt        = '0;
          iss_more_nxt   = 1'b1;
          free_found_nxt = 1'b0;
          seen_nxt       = '0;
          res_nxt        = '0;
          res_nxt.halted = halted_r;
          if (in_data.op == OP_TICK && halted_r) begin
            iss_more_nxt = 1'b0;
            state_nxt    = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        mem_re = iss_more_r;
        if (iss_more_r) begin
          pv_nxt = 1'b1;
          p_nxt  = iss_r;
          if (iss_r == LAST) begin
            iss_more_nxt = 1'b0;
          end else begin
            iss_nxt = iss_r + 1'b1;
          end
        end
        if (pv_r) begin
          case (op_r)
            OP_REGISTER: begin
              if (key_hit) begin
                mem_we             = 1'b1;
                mem_wdata.timeout    = tmo_r;
                mem_wdata.miss_limit = lim_r;
                mem_wdata.elapsed    = 16'd0;
                res_nxt.slot_index = 4'(p_r);
                stop               = 1'b1;
              end else begin
                if (!active_r[p_r] && !free_found_r) begin
                  free_found_nxt = 1'b1;
                  free_idx_nxt   = p_r;
                end
                if (last_p) begin
                  stop = 1'b1;
                  if (free_found_r || !active_r[p_r]) begin
                    mem_we               = 1'b1;
                    mem_waddr            = fidx;
                    mem_wdata.key        = key_r;
                    mem_wdata.timeout    = tmo_r;
                    mem_wdata.miss_limit = lim_r;
                    mem_wdata.misses     = 8'd0;
                    mem_wdata.elapsed    = 16'd0;
                    active_nxt[fidx]     = 1'b1;
                    fed_nxt[fidx]        = 1'b0;
                    res_nxt.slot_index   = 4'(fidx);
                  end else begin
                    res_nxt.status = STAT_FULL;
                  end
                end
              end
            end
            OP_UNREGISTER: begin
              if (key_hit) begin
                active_nxt[p_r]    = 1'b0;
                fed_nxt[p_r]       = 1'b0;
                res_nxt.slot_index = 4'(p_r);
                stop               = 1'b1;
              end else if (last_p) begin
                res_nxt.status = STAT_NOT_FOUND;
                stop           = 1'b1;
              end
            end
            OP_FEED: begin
              if (key_hit) begin
                fed_nxt[p_r]       = 1'b1;
                res_nxt.slot_index = 4'(p_r);
                stop               = 1'b1;
              end else if (last_p) begin
                res_nxt.status = STAT_NOT_FOUND;
                stop           = 1'b1;
              end
            end
            default: begin
              if (active_r[p_r]) begin
                mem_we = 1'b1;
                if (fed_r[p_r]) begin
                  fed_nxt[p_r]      = 1'b0;
                  mem_wdata.elapsed = 16'd0;
                  mem_wdata.misses  = 8'd0;
                end else begin
                  mem_wdata = upd.nxt;
                  if (upd.hit && seen_r != 5'd31) begin
                    seen_nxt = seen_r + 5'd1;
                  end
                  if (upd.stuck) begin
                    res_nxt.stuck      = 1'b1;
                    res_nxt.stuck_slot = 4'(p_r);
                    halted_nxt         = 1'b1;
                    stop               = 1'b1;
                  end
                end
              end
              if (last_p) begin
                stop = 1'b1;
              end
              res_nxt.timeouts_seen = seen_nxt;
            end
          endcase
        end
        if (stop) begin
          // drop any read still in flight
          iss_more_nxt   = 1'b0;
          pv_nxt         = 1'b0;
          res_nxt.halted = halted_nxt;
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_more_r  <= 1'b0;
      pv_r        <= 1'b0;
      halted_r    <= 1'b0;
      active_r    <= '0;
      fed_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      iss_more_r <= iss_more_nxt;
      pv_r       <= pv_nxt;
      halted_r   <= halted_nxt;
      active_r   <= active_nxt;
      fed_r      <= fed_nxt;
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    tmo_r        <= tmo_nxt;
    lim_r        <= lim_nxt;
    iss_r        <= iss_nxt;
    p_r          <= p_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    seen_r       <= seen_nxt;
    res_r        <= res_nxt;
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_r <= res_r;
    end
  end

  // once halted, only reset clears it
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag dropped");

  // a slot memory write must never hit the address being read in the same cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != iss_r))
    else $error("slot memory read/write collision");

  // a beat reporting a stuck slot always reports the block halted
  a_stuck_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.stuck) |-> out_r.halted)
    else $error("stuck without halted");

  // read data is consumed only while walking the table
  a_pv_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == ST_SCAN))
    else $error("read data pending outside scan");

endmodule
`default_nettype wire

/* design/hbw_mem.sv */
`default_nettype none
module hbw_mem import hbw_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/hbw_slot_upd.sv */
`default_nettype none
module hbw_slot_upd import hbw_pkg::*; (
  input  wire entry_t ent,
  output upd_t        upd
);

  logic [15:0] elapsed_inc;
  logic [7:0]  misses_new;
  logic        hit;

  always_comb begin
    elapsed_inc = (ent.elapsed != 16'hFFFF) ? ent.elapsed + 16'd1 : ent.elapsed;
    hit         = (elapsed_inc >= ent.timeout);
    misses_new  = ent.misses;
    if (hit && ent.misses != 8'hFF) begin
      misses_new = ent.misses + 8'd1;
    end
    upd.nxt         = ent;
    upd.nxt.elapsed = hit ? 16'd0 : elapsed_inc;
    upd.nxt.misses  = misses_new;
    upd.hit         = hit;
    upd.stuck       = hit && (misses_new >= ent.miss_limit);
  end

endmodule
`default_nettype wire
